// ===== rtl/sise_pkg.sv =====
// ----------------------------------------------------------------------------
// Sorted integer set engine package
// Shared types and codes for the sorted integer set engine.
// ----------------------------------------------------------------------------
package sise_pkg;

  localparam int unsigned ValueWidth  = 32;
  localparam int unsigned ActionWidth = 3;

  localparam logic [ActionWidth-1:0] ACT_INSERT = 3'd0;
  localparam logic [ActionWidth-1:0] ACT_REMOVE = 3'd1;
  localparam logic [ActionWidth-1:0] ACT_MARK   = 3'd2;
  localparam logic [ActionWidth-1:0] ACT_EMIT   = 3'd3;
  localparam logic [ActionWidth-1:0] ACT_ISECT  = 3'd4;

  typedef struct packed {
    logic                  mark;
    logic [ValueWidth-1:0] value;
  } entry_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SRCH_RD,
    ST_SRCH_CHK,
    ST_APPLY,
    ST_SHIFT_RD,
    ST_SHIFT_WR,
    ST_CMP_RD,
    ST_CMP_CHK,
    ST_EMIT_START,
    ST_EMIT_RD,
    ST_EMIT_OUT
  } state_t;

endpackage

// ===== rtl/sise_mem.sv =====
// ----------------------------------------------------------------------------
// Sorted integer set entry memory
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module sise_mem
  import sise_pkg::*;
#(
  parameter int unsigned DEPTH = 64,
  parameter int unsigned AW    = 6
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  entry_t        wdata,
  input  logic          re,
  input  logic [AW-1:0] raddr,
  output entry_t        rdata
);

  entry_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== rtl/sorted_integer_set_engine_unit.sv =====
// ----------------------------------------------------------------------------
// Sorted integer set engine
// Keeps an ordered set of distinct signed values in one memory; supports
// insert, remove, intersect marking and ordered emission of the contents.
// Insert/remove/mark search the set in order, and insert/remove then shift the
// following entries, all through the single memory read port; an intersect
// compacts the marked entries before emitting them in order.
// One item is processed at a time. Reset empties the set; no clearing pass.
// ----------------------------------------------------------------------------
module sorted_integer_set_engine_unit
  import sise_pkg::*;
#(
  parameter int unsigned CAPACITY = 64
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [ActionWidth-1:0]        action,
  input  logic signed [ValueWidth-1:0]  value,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic signed [ValueWidth-1:0]  element,
  output logic                          last,
  output logic                          empty_res,
  output logic                          dropped
);

  localparam int unsigned AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned CW = $clog2(CAPACITY + 1);
  localparam logic [CW-1:0] CapCount = CW'(CAPACITY);
  localparam logic [CW-1:0] One = CW'(1);

  state_t state, state_next;

  logic [ActionWidth-1:0]       act;
  logic signed [ValueWidth-1:0] val;
  logic [CW-1:0] count, count_next;
  logic [CW-1:0] idx, idx_next;
  logic [CW-1:0] wptr, wptr_next;
  logic [CW-1:0] pos, pos_next;
  logic          found, found_next;
  logic          ovf, ovf_next;
  logic          dflag, dflag_next;

  logic          mem_we, mem_re;
  logic [AW-1:0] mem_waddr, mem_raddr;
  entry_t        mem_wdata, mem_rdata;

  logic          in_xfer;
  logic          load_ok;
  logic          load;
  logic signed [ValueWidth-1:0] load_element;
  logic          load_last, load_empty;
  logic          rd_less;
  logic          emit_final;

  assign in_stall  = (state != ST_IDLE);
  assign in_xfer   = in_valid && !in_stall;
  assign load_ok   = !out_valid || !out_stall;
  assign rd_less   = $signed(mem_rdata.value) < val;
  assign emit_final = ((idx + One) == count);

  sise_mem #(
    .DEPTH(CAPACITY),
    .AW   (AW)
  ) u_mem (
    .clk  (clk),
    .we   (mem_we),
    .waddr(mem_waddr),
    .wdata(mem_wdata),
    .re   (mem_re),
    .raddr(mem_raddr),
    .rdata(mem_rdata)
  );

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_xfer) begin
          case (action) inside
            ACT_INSERT, ACT_REMOVE, ACT_MARK: state_next = ST_SRCH_RD;
            ACT_EMIT:  state_next = ST_EMIT_START;
            ACT_ISECT: state_next = ST_CMP_RD;
            default:   state_next = ST_IDLE;
          endcase
        end
      end
      ST_SRCH_RD: state_next = (idx == count) ? ST_APPLY : ST_SRCH_CHK;
      ST_SRCH_CHK: state_next = rd_less ? ST_SRCH_RD : ST_APPLY;
      ST_APPLY: begin
        state_next = ST_IDLE;
        if (act == ACT_INSERT && !found && count != CapCount) begin
          state_next = ST_SHIFT_RD;
        end else if (act == ACT_REMOVE && found) begin
          state_next = ST_SHIFT_RD;
        end
      end
      ST_SHIFT_RD: begin
        if (act == ACT_INSERT) begin
          state_next = (idx == pos) ? ST_IDLE : ST_SHIFT_WR;
        end else begin
          state_next = ((idx + One) >= count) ? ST_IDLE : ST_SHIFT_WR;
        end
      end
      ST_SHIFT_WR: state_next = ST_SHIFT_RD;
      ST_CMP_RD: state_next = (idx == count) ? ST_EMIT_START : ST_CMP_CHK;
      ST_CMP_CHK: state_next = ST_CMP_RD;
      ST_EMIT_START: state_next = ST_EMIT_RD;
      ST_EMIT_RD: begin
        if (count == '0) begin
          state_next = load_ok ? ST_IDLE : ST_EMIT_RD;
        end else begin
          state_next = ST_EMIT_OUT;
        end
      end
      ST_EMIT_OUT: begin
        if (load_ok) begin
          state_next = emit_final ? ST_IDLE : ST_EMIT_RD;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    count_next   = count;
    idx_next     = idx;
    wptr_next    = wptr;
    pos_next     = pos;
    found_next   = found;
    ovf_next     = ovf;
    dflag_next   = dflag;
    mem_we       = 1'b0;
    mem_waddr    = idx[AW-1:0];
    mem_wdata    = '{mark: 1'b0, value: val};
    mem_re       = 1'b0;
    mem_raddr    = idx[AW-1:0];
    load         = 1'b0;
    load_element = mem_rdata.value;
    load_last    = emit_final;
    load_empty   = 1'b0;
    unique case (state)
      ST_IDLE: begin
        idx_next  = '0;
        wptr_next = '0;
      end
      ST_SRCH_RD: begin
        if (idx == count) begin
          pos_next   = count;
          found_next = 1'b0;
        end else begin
          mem_re = 1'b1;
        end
      end
      ST_SRCH_CHK: begin
        if (rd_less) begin
          idx_next = idx + One;
        end else begin
          pos_next   = idx;
          found_next = (mem_rdata.value == val);
        end
      end
      ST_APPLY: begin
        if (act == ACT_INSERT && !found) begin
          if (count == CapCount) begin
            ovf_next = 1'b1;
          end else begin
            idx_next = count;
          end
        end else if (act == ACT_REMOVE && found) begin
          idx_next = pos;
        end else if (act == ACT_MARK && found) begin
          mem_we    = 1'b1;
          mem_waddr = pos[AW-1:0];
          mem_wdata = '{mark: 1'b1, value: val};
        end
      end
      ST_SHIFT_RD: begin
        if (act == ACT_INSERT) begin
          if (idx == pos) begin
            mem_we     = 1'b1;
            mem_waddr  = pos[AW-1:0];
            count_next = count + One;
          end else begin
            mem_re    = 1'b1;
            mem_raddr = AW'(idx - One);
          end
        end else begin
          if ((idx + One) >= count) begin
            count_next = count - One;
          end else begin
            mem_re    = 1'b1;
            mem_raddr = AW'(idx + One);
          end
        end
      end
      ST_SHIFT_WR: begin
        mem_we    = 1'b1;
        mem_wdata = mem_rdata;
        idx_next  = (act == ACT_INSERT) ? (idx - One) : (idx + One);
      end
      ST_CMP_RD: begin
        if (idx == count) begin
          count_next = wptr;
        end else begin
          mem_re = 1'b1;
        end
      end
      ST_CMP_CHK: begin
        if (mem_rdata.mark) begin
          mem_we    = 1'b1;
          mem_waddr = wptr[AW-1:0];
          mem_wdata = '{mark: 1'b0, value: mem_rdata.value};
          wptr_next = wptr + One;
        end
        idx_next = idx + One;
      end
      ST_EMIT_START: begin
        dflag_next = ovf;
        ovf_next   = 1'b0;
        idx_next   = '0;
      end
      ST_EMIT_RD: begin
        if (count == '0) begin
          load         = load_ok;
          load_element = '0;
          load_last    = 1'b1;
          load_empty   = 1'b1;
        end else begin
          mem_re = 1'b1;
        end
      end
      ST_EMIT_OUT: begin
        if (load_ok) begin
          load     = 1'b1;
          idx_next = idx + One;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      count     <= '0;
      ovf       <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      count <= count_next;
      ovf   <= ovf_next;
      if (load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    idx   <= idx_next;
    wptr  <= wptr_next;
    pos   <= pos_next;
    found <= found_next;
    dflag <= dflag_next;
    if (in_xfer) begin
      act <= action;
      val <= value;
    end
    if (load) begin
      element   <= load_element;
      last      <= load_last;
      empty_res <= load_empty;
      dropped   <= dflag;
    end
  end

  a_count_bound : assert property (@(posedge clk) disable iff (rst)
    count <= CapCount)
    else $error("entry count exceeds capacity");

  a_count_step : assert property (@(posedge clk) disable iff (rst)
    (state != ST_CMP_RD) |=> (count == $past(count) || count == $past(count) + One ||
                             count + One == $past(count)))
    else $error("entry count moved by more than one outside compaction");

  a_emit_index : assert property (@(posedge clk) disable iff (rst)
    (state == ST_EMIT_OUT) |-> (idx < count))
    else $error("emission index beyond entry count");

  a_search_index : assert property (@(posedge clk) disable iff (rst)
    (state == ST_SRCH_RD || state == ST_CMP_RD) |-> (idx <= count))
    else $error("scan index beyond entry count");

endmodule

// ===== tb/sv/tb_sorted_integer_set_engine_unit.sv =====
// ----------------------------------------------------------------------------
// Sorted integer set engine testbench
// Drives inserts, removes, intersect marks and emissions with random gaps on
// both channels, predicts every emitted element from a behavioral model of
// the ordered set, and checks each result transfer field by field.
// ----------------------------------------------------------------------------
module tb_sorted_integer_set_engine_unit;
  import sise_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int Capacity = 64;
  localparam int IdleLimit = 20000;

  typedef struct {
    logic [ActionWidth-1:0] act;
    logic [ValueWidth-1:0]  val;
  } op_t;

  typedef struct {
    logic [ValueWidth-1:0] element;
    logic                  last;
    logic                  empty_res;
    logic                  dropped;
  } emit_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [ActionWidth-1:0] action = '0;
  logic signed [ValueWidth-1:0] value = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [ValueWidth-1:0] element;
  logic last, empty_res, dropped;

  op_t   pending_ops[$];
  emit_t expected_emits[$];
  int    error_count = 0;
  int    idle_cycles = 0;
  int    send_gap = 0;
  int    hold_cycles = 0;
  bit    hold_request = 1'b0;
  bit    stimulus_done = 1'b0;

  logic [ValueWidth-1:0] set_vals[$];
  logic                  set_marks[$];
  logic                  overflow_flag = 1'b0;

  sorted_integer_set_engine_unit #(.CAPACITY(Capacity)) uut (.*);

  always #5 clk = ~clk;

  function automatic bit is_less(logic [31:0] a, logic [31:0] b);
    return $signed(a) < $signed(b);
  endfunction

  task automatic push_emission();
    emit_t e;
    e.dropped = overflow_flag;
    overflow_flag = 1'b0;
    if (set_vals.size() == 0) begin
      e.element = '0;
      e.last = 1'b1;
      e.empty_res = 1'b1;
      expected_emits.push_back(e);
    end else begin
      foreach (set_vals[i]) begin
        e.element = set_vals[i];
        e.last = (i == set_vals.size() - 1);
        e.empty_res = 1'b0;
        expected_emits.push_back(e);
      end
    end
  endtask

  task automatic apply_set_op(op_t op);
    int pos;
    bit hit;
    pos = 0;
    while (pos < set_vals.size() && is_less(set_vals[pos], op.val)) pos++;
    hit = pos < set_vals.size() && set_vals[pos] == op.val;
    case (op.act)
      ACT_INSERT: begin
        if (!hit) begin
          if (set_vals.size() >= Capacity) begin
            overflow_flag = 1'b1;
          end else begin
            set_vals.insert(pos, op.val);
            set_marks.insert(pos, 1'b0);
          end
        end
      end
      ACT_REMOVE: begin
        if (hit) begin
          set_vals.delete(pos);
          set_marks.delete(pos);
        end
      end
      ACT_MARK: begin
        if (hit) set_marks[pos] = 1'b1;
      end
      ACT_EMIT: push_emission();
      ACT_ISECT: begin
        for (int i = set_vals.size() - 1; i >= 0; i--) begin
          if (!set_marks[i]) begin
            set_vals.delete(i);
            set_marks.delete(i);
          end else begin
            set_marks[i] = 1'b0;
          end
        end
        push_emission();
      end
      default: ;
    endcase
  endtask

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch on %s: got %0h, expected %0h at %0t", what, got, want, $realtime);
    error_count++;
  endtask

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(4, 30);
  endfunction

  // Sender: a gap is drawn as each item goes up; a held item is never lowered.
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (in_valid && in_stall) begin
    end else if (send_gap > 0) begin
      in_valid <= 1'b0;
      send_gap <= send_gap - 1;
    end else if (pending_ops.size() > 0 && pending_ops[0].act == 3'd7 &&
                 pending_ops[0].val == '1) begin
      // Barrier item: wait for every expected result before going on.
      in_valid <= 1'b0;
      if (expected_emits.size() == 0) void'(pending_ops.pop_front());
    end else if (pending_ops.size() > 0) begin
      op_t op;
      op = pending_ops.pop_front();
      in_valid <= 1'b1;
      action <= op.act;
      value <= op.val;
      apply_set_op(op);
      send_gap <= pick_gap();
    end else begin
      in_valid <= 1'b0;
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else if (hold_cycles > 0) begin
      out_stall <= 1'b1;
      hold_cycles <= hold_cycles - 1;
    end else if (hold_request) begin
      hold_request <= 1'b0;
      hold_cycles <= 400;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(0, 99) < 25) ? 1'b1 :
                   ($urandom_range(0, 99) < 3);
    end
  end

  always @(posedge clk) begin
    if (!rst) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (out_valid && !out_stall) begin
        if (expected_emits.size() == 0) begin
          report_mismatch("unexpected transfer", element, '0);
        end else begin
          emit_t w;
          w = expected_emits.pop_front();
          if (element !== w.element) report_mismatch("element", element, w.element);
          if (last !== w.last) report_mismatch("last", 32'(last), 32'(w.last));
          if (empty_res !== w.empty_res) begin
            report_mismatch("empty_res", 32'(empty_res), 32'(w.empty_res));
          end
          if (dropped !== w.dropped) begin
            report_mismatch("dropped", 32'(dropped), 32'(w.dropped));
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    if (idle_cycles >= IdleLimit) begin
      $display("simulation failed");
      $finish;
    end
  end

  function automatic logic [31:0] rand_value(int span);
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return $urandom();
    if (r == 1) return 32'h8000_0000 + $urandom_range(0, 3);
    if (r == 2) return 32'h7fff_fffc + $urandom_range(0, 3);
    return $urandom_range(0, span) - span / 2;
  endfunction

  task automatic add_op(logic [2:0] act, logic [31:0] val);
    op_t op;
    op.act = act;
    op.val = val;
    pending_ops.push_back(op);
  endtask

  task automatic add_barrier();
    add_op(3'd7, '1);
  endtask

  initial begin
    logic [31:0] held[$];
    int n;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    add_op(ACT_EMIT, 32'h1234);
    add_op(ACT_INSERT, 32'h8000_0000);
    add_op(ACT_INSERT, 32'h7fff_ffff);
    add_op(ACT_INSERT, 32'hffff_ffff);
    add_op(ACT_INSERT, 32'h0);
    add_op(ACT_INSERT, 32'h0);
    add_op(ACT_REMOVE, 32'h5);
    add_op(ACT_MARK, 32'h6);
    add_op(ACT_MARK, 32'h7fff_ffff);
    add_op(ACT_MARK, 32'h8000_0000);
    add_op(ACT_INSERT, 32'h5555_aaaa);
    add_op(ACT_EMIT, 32'h0);
    add_op(ACT_REMOVE, 32'h0);
    add_op(3'd5, 32'h1);
    add_op(3'd6, 32'h2);
    add_op(3'd7, 32'h3);
    add_op(ACT_ISECT, 32'haaaa_5555);
    add_op(ACT_ISECT, 32'h0);
    add_barrier();

    // Fill past capacity and emit, then remove the inserted values and emit again.
    for (int i = 0; i < Capacity + 3; i++) add_op(ACT_INSERT, i * 3 - 90);
    add_op(ACT_EMIT, 32'h0);
    add_op(ACT_EMIT, 32'h0);
    add_op(ACT_EMIT, 32'h0);
    add_barrier();
    for (int i = 0; i < Capacity; i++) add_op(ACT_REMOVE, i * 3 - 90);
    add_op(ACT_EMIT, 32'h0);
    add_barrier();

    n = 0;
    while (n < 50) begin
      int burst;
      held.delete();
      burst = $urandom_range(1, 12);
      for (int i = 0; i < burst; i++) begin
        logic [31:0] v;
        v = rand_value(($urandom_range(0, 3) == 0) ? 2000 : 40);
        held.push_back(v);
        add_op(ACT_INSERT, v);
        n++;
      end
      for (int i = 0; i < $urandom_range(0, 6); i++) begin
        case ($urandom_range(0, 5))
          0: add_op(ACT_REMOVE, held[$urandom_range(0, held.size() - 1)]);
          1: add_op(ACT_REMOVE, rand_value(40));
          2: add_op(ACT_MARK, rand_value(40));
          3: add_op(3'($urandom_range(5, 7)), $urandom());
          default: add_op(ACT_MARK, held[$urandom_range(0, held.size() - 1)]);
        endcase
        n++;
      end
      add_op(($urandom_range(0, 1) == 1) ? ACT_ISECT : ACT_EMIT, $urandom());
      n++;
      if ($urandom_range(0, 15) == 0) add_barrier();
    end
    stimulus_done = 1'b1;
  end

  initial begin
    @(negedge rst);
    wait (out_valid && !last);
    @(posedge clk);
    hold_request <= 1'b1;
    wait (stimulus_done && pending_ops.size() == 0 && !in_valid);
    wait (expected_emits.size() == 0);
    repeat (300) @(posedge clk);
    if (error_count == 0 && expected_emits.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/sise_pkg.sv
rtl/sise_mem.sv
rtl/sorted_integer_set_engine_unit.sv
tb/sv/tb_sorted_integer_set_engine_unit.sv
